[rtl/sdrct_pkg.sv]
// sdrct_pkg: shared types and constants for the SD request completion tracker.
// No dependencies; imported by sdrct_core, sd_request_completion_tracker and the sim files.
`timescale 1ns / 1ps

package sdrct_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BLK_W  = 16;
  localparam int unsigned IDX_W  = 6;

  localparam logic [IDX_W-1:0] TUNING_RESET = 6'd19;

  localparam int unsigned BYTE_SHIFT = 8;
  localparam int unsigned TOP_SHIFT  = 24;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_IRQ   = 1'b1;

  // response kinds
  localparam logic [1:0] RESP_NONE    = 2'd0;
  localparam logic [1:0] RESP_136     = 2'd1;
  localparam logic [1:0] RESP_48      = 2'd2;
  localparam logic [1:0] RESP_48_BUSY = 2'd3;

  // irq_mask bit positions
  localparam int unsigned IRQ_CC  = 0;
  localparam int unsigned IRQ_BRR = 1;
  localparam int unsigned IRQ_BWR = 2;
  localparam int unsigned IRQ_TC  = 3;
  localparam int unsigned IRQ_ERR = 4;

  // result kinds
  localparam logic [1:0] RK_START = 2'd0;
  localparam logic [1:0] RK_NONE  = 2'd1;
  localparam logic [1:0] RK_DONE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IO_ERR  = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NOT_SUP = 2'd3;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  cmd_index;
    logic [1:0]        resp_kind;
    logic              data_present;
    logic              dma_requested;
    logic [4:0]        irq_mask;
    logic [WORD_W-1:0] rsp_word0;
    logic [WORD_W-1:0] rsp_word1;
    logic [WORD_W-1:0] rsp_word2;
    logic [WORD_W-1:0] rsp_word3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [1:0]        status;
    logic [WORD_W-1:0] resp_out0;
    logic [WORD_W-1:0] resp_out1;
    logic [WORD_W-1:0] resp_out2;
    logic [WORD_W-1:0] resp_out3;
    logic [BLK_W-1:0]  blocks_done;
  } out_item_t;

endpackage

[rtl/sdrct_core.sv]
// sdrct_core: request state, response store and per-transfer result logic.
// Depends on sdrct_pkg.
`timescale 1ns / 1ps

module sdrct_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [sdrct_pkg::IDX_W-1:0] tuning_idx,
  input  sdrct_pkg::in_item_t       item,
  output sdrct_pkg::out_item_t      result
);
  import sdrct_pkg::*;

  logic                   cmd_pending_r, cmd_pending_nxt;
  logic                   data_pending_r, data_pending_nxt;
  logic                   data_fin_r, data_fin_nxt;
  logic                   data_payload_r, data_payload_nxt;
  logic [IDX_W-1:0]       cur_cmd_r, cur_cmd_nxt;
  logic [1:0]             cur_rk_r, cur_rk_nxt;
  logic [BLK_W-1:0]       blk_cnt_r, blk_cnt_nxt;
  logic [3:0][WORD_W-1:0] store_r, store_nxt;

  logic                   completed;
  logic [1:0]             st;
  logic [BLK_W-1:0]       snap;

  always_comb begin
    cmd_pending_nxt  = cmd_pending_r;
    data_pending_nxt = data_pending_r;
    data_fin_nxt     = data_fin_r;
    data_payload_nxt = data_payload_r;
    cur_cmd_nxt      = cur_cmd_r;
    cur_rk_nxt       = cur_rk_r;
    blk_cnt_nxt      = blk_cnt_r;
    store_nxt        = store_r;
    completed        = 1'b0;
    st               = ST_OK;
    snap             = '0;
    result           = '0;

    if (item.command == CMD_START) begin
      if (cmd_pending_r || data_pending_r) begin
        st = ST_BUSY;
      end else if (item.dma_requested) begin
        st = ST_NOT_SUP;
      end else begin
        st               = ST_OK;
        cmd_pending_nxt  = 1'b1;
        data_pending_nxt = item.data_present || (item.resp_kind == RESP_48_BUSY);
        data_payload_nxt = item.data_present;
        data_fin_nxt     = 1'b0;
        cur_cmd_nxt      = item.cmd_index;
        cur_rk_nxt       = item.resp_kind;
        blk_cnt_nxt      = '0;
        store_nxt        = '0;
      end
      result.result_kind = RK_START;
      result.status      = st;
    end else begin
      if (item.irq_mask[IRQ_CC] && cmd_pending_nxt) begin
        if (cur_rk_nxt == RESP_136) begin
          store_nxt[0] = {item.rsp_word0[TOP_SHIFT-1:0], 8'h00};
          store_nxt[1] = {item.rsp_word1[TOP_SHIFT-1:0], item.rsp_word0[WORD_W-1:TOP_SHIFT]};
          store_nxt[2] = {item.rsp_word2[TOP_SHIFT-1:0], item.rsp_word1[WORD_W-1:TOP_SHIFT]};
          store_nxt[3] = {item.rsp_word3[TOP_SHIFT-1:0], item.rsp_word2[WORD_W-1:TOP_SHIFT]};
        end else if (cur_rk_nxt != RESP_NONE) begin
          store_nxt[0] = item.rsp_word0;
          store_nxt[1] = item.rsp_word1;
        end
        if (!data_pending_nxt || data_fin_nxt) begin
          completed        = 1'b1;
          snap             = blk_cnt_nxt;
          cmd_pending_nxt  = 1'b0;
          data_pending_nxt = 1'b0;
          data_fin_nxt     = 1'b0;
          data_payload_nxt = 1'b0;
          blk_cnt_nxt      = '0;
        end else begin
          cmd_pending_nxt = 1'b0;
        end
      end
      if (item.irq_mask[IRQ_BRR] && data_pending_nxt && data_payload_nxt) begin
        if (cur_cmd_nxt == tuning_idx) begin
          completed        = 1'b1;
          snap             = blk_cnt_nxt;
          cmd_pending_nxt  = 1'b0;
          data_pending_nxt = 1'b0;
          data_fin_nxt     = 1'b0;
          data_payload_nxt = 1'b0;
          blk_cnt_nxt      = '0;
        end else begin
          blk_cnt_nxt = blk_cnt_nxt + BLK_W'(1);
        end
      end
      if (item.irq_mask[IRQ_BWR] && data_pending_nxt && data_payload_nxt) begin
        blk_cnt_nxt = blk_cnt_nxt + BLK_W'(1);
      end
      if (item.irq_mask[IRQ_TC] && data_pending_nxt) begin
        if (cmd_pending_nxt) begin
          data_fin_nxt = 1'b1;
        end else begin
          completed        = 1'b1;
          snap             = blk_cnt_nxt;
          data_pending_nxt = 1'b0;
          data_fin_nxt     = 1'b0;
          data_payload_nxt = 1'b0;
          blk_cnt_nxt      = '0;
        end
      end
      if (item.irq_mask[IRQ_ERR] && (cmd_pending_nxt || data_pending_nxt)) begin
        completed        = 1'b1;
        st               = ST_IO_ERR;
        snap             = blk_cnt_nxt;
        cmd_pending_nxt  = 1'b0;
        data_pending_nxt = 1'b0;
        data_fin_nxt     = 1'b0;
        data_payload_nxt = 1'b0;
        blk_cnt_nxt      = '0;
      end
      result.result_kind = completed ? RK_DONE : RK_NONE;
      result.status      = completed ? st : ST_OK;
      result.resp_out0   = store_nxt[0];
      result.resp_out1   = store_nxt[1];
      result.resp_out2   = store_nxt[2];
      result.resp_out3   = store_nxt[3];
      result.blocks_done = completed ? snap : blk_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_pending_r  <= 1'b0;
      data_pending_r <= 1'b0;
      data_fin_r     <= 1'b0;
      data_payload_r <= 1'b0;
      cur_cmd_r      <= '0;
      cur_rk_r       <= RESP_NONE;
      blk_cnt_r      <= '0;
      store_r        <= '0;
    end else if (fire) begin
      cmd_pending_r  <= cmd_pending_nxt;
      data_pending_r <= data_pending_nxt;
      data_fin_r     <= data_fin_nxt;
      data_payload_r <= data_payload_nxt;
      cur_cmd_r      <= cur_cmd_nxt;
      cur_rk_r       <= cur_rk_nxt;
      blk_cnt_r      <= blk_cnt_nxt;
      store_r        <= store_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.result_kind == RK_DONE |=> !cmd_pending_r && !data_pending_r)
    else $error("completion left a stage pending");

  a_start_ok_pends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.command == CMD_START && result.status == ST_OK |=> cmd_pending_r)
    else $error("accepted start did not mark command pending");

  a_done_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    data_fin_r |-> data_pending_r)
    else $error("data stage done without pending data stage");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(blk_cnt_r) && $stable(cmd_pending_r))
    else $error("state changed without a transfer");
`endif

endmodule

[rtl/sd_request_completion_tracker.sv]
// sd_request_completion_tracker: top level with input register, result register
// and the tuning-command config register. Depends on sdrct_pkg and sdrct_core.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid/in_stall/in_item carries start requests and interrupt
//   status events; each transfer yields exactly one result on out_valid/
//   out_stall/out_item, in order.
//   cfg_wr_en/cfg_wr_data write the tuning command index (reset value 19);
//   write it only while no transfer is in flight.
//   Timing: an accepted item is held in the input register, is evaluated against
//   the tracker state there, and its result is captured in the result register
//   when it advances, from which it shows on out_item.
//   Throughput: one item per cycle unless out_stall holds a result; a single
//   pass of flag logic and two 16-bit increments lies between the two registers.
//   Reset (rst_n low, synchronous) clears both registers' valid bits, all
//   pending flags, the block counter and the response store.
//   When out_stall holds a result, the input register keeps its item and
//   in_stall rises once it is full; nothing is dropped.
module sd_request_completion_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sdrct_pkg::in_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sdrct_pkg::out_item_t        out_item,
  input  logic                        cfg_wr_en,
  input  logic [sdrct_pkg::IDX_W-1:0] cfg_wr_data
);
  import sdrct_pkg::*;

  logic             in_valid_r, in_valid_nxt;
  in_item_t         in_item_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic [IDX_W-1:0] tuning_r;
  logic             advance;
  logic             in_take;
  out_item_t        core_result;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    in_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);
  end

  sdrct_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .tuning_idx (tuning_r),
    .item       (in_item_r),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tuning_r    <= TUNING_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tuning_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= core_result;
    end
  end

endmodule

[sim/sdrct_checker.sv]
// sdrct_checker: watches both channels of the SD request completion tracker, predicts each
// result from the accepted transfers and compares it field by field. Depends on sdrct_pkg.
`timescale 1ns / 1ps

module sdrct_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  sdrct_pkg::in_item_t         in_item,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  sdrct_pkg::out_item_t        out_item,
  input  logic                        cfg_wr_en,
  input  logic [sdrct_pkg::IDX_W-1:0] cfg_wr_data,
  output int                          fail_count,
  output int                          outstanding
);
  import sdrct_pkg::*;

  logic [IDX_W-1:0]  tune_idx;
  logic              cmd_busy;
  logic              data_busy;
  logic              data_fin;
  logic              data_payload;
  logic [IDX_W-1:0]  cur_cmd;
  logic [1:0]        cur_rk;
  logic [BLK_W-1:0]  blk_cnt;
  logic [WORD_W-1:0] rsp_store [4];

  out_item_t expected_results [$];
  out_item_t want;

  function automatic void clear_request();
    cmd_busy     = 1'b0;
    data_busy    = 1'b0;
    data_fin     = 1'b0;
    data_payload = 1'b0;
    blk_cnt      = '0;
  endfunction

  task automatic reset_tracker();
    clear_request();
    tune_idx = TUNING_RESET;
    cur_cmd  = '0;
    cur_rk   = RESP_NONE;
    foreach (rsp_store[k]) rsp_store[k] = '0;
  endtask

  function automatic out_item_t track(in_item_t it);
    out_item_t        r;
    logic             done;
    logic [1:0]       st;
    logic [BLK_W-1:0] snap;
    r    = '0;
    done = 1'b0;
    st   = ST_OK;
    snap = '0;
    if (it.command == CMD_START) begin
      r.result_kind = RK_START;
      if (cmd_busy || data_busy) begin
        r.status = ST_BUSY;
      end else if (it.dma_requested) begin
        r.status = ST_NOT_SUP;
      end else begin
        r.status     = ST_OK;
        cmd_busy     = 1'b1;
        data_busy    = it.data_present || (it.resp_kind == RESP_48_BUSY);
        data_payload = it.data_present;
        data_fin     = 1'b0;
        cur_cmd      = it.cmd_index;
        cur_rk       = it.resp_kind;
        blk_cnt      = '0;
        foreach (rsp_store[k]) rsp_store[k] = '0;
      end
    end else begin
      if (it.irq_mask[IRQ_CC] && cmd_busy) begin
        if (cur_rk == RESP_136) begin
          rsp_store[0] = it.rsp_word0 << BYTE_SHIFT;
          rsp_store[1] = (it.rsp_word1 << BYTE_SHIFT) | (it.rsp_word0 >> TOP_SHIFT);
          rsp_store[2] = (it.rsp_word2 << BYTE_SHIFT) | (it.rsp_word1 >> TOP_SHIFT);
          rsp_store[3] = (it.rsp_word3 << BYTE_SHIFT) | (it.rsp_word2 >> TOP_SHIFT);
        end else if (cur_rk != RESP_NONE) begin
          rsp_store[0] = it.rsp_word0;
          rsp_store[1] = it.rsp_word1;
        end
        if (!data_busy || data_fin) begin
          done = 1'b1;
          snap = blk_cnt;
          clear_request();
        end else begin
          cmd_busy = 1'b0;
        end
      end
      if (it.irq_mask[IRQ_BRR] && data_busy && data_payload) begin
        if (cur_cmd == tune_idx) begin
          done = 1'b1;
          snap = blk_cnt;
          clear_request();
        end else begin
          blk_cnt = blk_cnt + BLK_W'(1);
        end
      end
      if (it.irq_mask[IRQ_BWR] && data_busy && data_payload) blk_cnt = blk_cnt + BLK_W'(1);
      if (it.irq_mask[IRQ_TC] && data_busy) begin
        if (cmd_busy) begin
          data_fin = 1'b1;
        end else begin
          done = 1'b1;
          snap = blk_cnt;
          clear_request();
        end
      end
      if (it.irq_mask[IRQ_ERR] && (cmd_busy || data_busy)) begin
        done = 1'b1;
        st   = ST_IO_ERR;
        snap = blk_cnt;
        clear_request();
      end
      r.result_kind = done ? RK_DONE : RK_NONE;
      r.status      = done ? st : ST_OK;
      r.resp_out0   = rsp_store[0];
      r.resp_out1   = rsp_store[1];
      r.resp_out2   = rsp_store[2];
      r.resp_out3   = rsp_store[3];
      r.blocks_done = done ? snap : blk_cnt;
    end
    return r;
  endfunction

  task automatic flag(string what, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (fail_count < 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, what, exp_v, act_v);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) flag(what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_tracker();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag("result transfer with none expected", '0, WORD_W'(out_item.result_kind));
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", WORD_W'(want.result_kind), WORD_W'(out_item.result_kind));
          check_field("status", WORD_W'(want.status), WORD_W'(out_item.status));
          check_field("resp_out0", want.resp_out0, out_item.resp_out0);
          check_field("resp_out1", want.resp_out1, out_item.resp_out1);
          check_field("resp_out2", want.resp_out2, out_item.resp_out2);
          check_field("resp_out3", want.resp_out3, out_item.resp_out3);
          check_field("blocks_done", WORD_W'(want.blocks_done), WORD_W'(out_item.blocks_done));
        end
      end
      if (cfg_wr_en) tune_idx = cfg_wr_data;
      if (in_valid && !in_stall) expected_results.push_back(track(in_item));
    end
    outstanding <= expected_results.size();
  end

endmodule

[sim/sd_request_completion_tracker_test.sv]
// sd_request_completion_tracker_test: drives start and interrupt transfers with directed
// and random sequences under several idle/stall mixes. Depends on sdrct_pkg, the block
// and sdrct_checker, which predicts and compares; this top only gives the verdict.
`timescale 1ns / 1ps

module sd_request_completion_tracker_test;
  import sdrct_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_item     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en   = 1'b0;
  logic [IDX_W-1:0] cfg_wr_data = '0;

  int               fail_count;
  int               outstanding;
  int               tx_idle  = 0;
  int               rx_stall = 0;
  logic             hold_req = 1'b0;
  int               sent     = 0;
  logic [IDX_W-1:0] tune_now = TUNING_RESET;

  sd_request_completion_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sdrct_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver; a requested hold-off keeps the result side stalled for a long stretch
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= (rx_stall > 0) && ($urandom_range(99) < rx_stall);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.command       = 1'($urandom);
    it.cmd_index     = IDX_W'($urandom);
    it.resp_kind     = 2'($urandom);
    it.data_present  = 1'($urandom);
    it.dma_requested = 1'($urandom);
    it.irq_mask      = 5'($urandom);
    it.rsp_word0     = rand_word();
    it.rsp_word1     = rand_word();
    it.rsp_word2     = rand_word();
    it.rsp_word3     = rand_word();
    return it;
  endfunction

  function automatic in_item_t mk_start(logic [IDX_W-1:0] idx, logic [1:0] rk, logic dp,
                                        logic dma);
    in_item_t it;
    it               = rand_item();
    it.command       = CMD_START;
    it.cmd_index     = idx;
    it.resp_kind     = rk;
    it.data_present  = dp;
    it.dma_requested = dma;
    return it;
  endfunction

  function automatic in_item_t mk_irq(logic [4:0] mask);
    in_item_t it;
    it          = rand_item();
    it.command  = CMD_IRQ;
    it.irq_mask = mask;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_tuning(input logic [IDX_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tune_now = v;
  endtask

  // start, command complete, some blocks, transfer complete; TC may come first, errors rarely
  task automatic run_sequence();
    logic [IDX_W-1:0] idx;
    int               nblk;
    idx  = ($urandom_range(3) == 0) ? tune_now : IDX_W'($urandom);
    nblk = $urandom_range(5);
    send(mk_start(idx, 2'($urandom), 1'($urandom), $urandom_range(9) == 0));
    if ($urandom_range(3) == 0) send(mk_irq(5'd1 << IRQ_TC));
    send(mk_irq(5'd1 << IRQ_CC));
    repeat (nblk) send(mk_irq(5'($urandom_range(1, 3)) << IRQ_BRR));
    if ($urandom_range(7) == 0) send(mk_irq(5'd1 << IRQ_ERR));
    send(mk_irq(5'd1 << IRQ_TC));
  endtask

  task automatic run_random(input int n);
    int first;
    first = sent;
    while (sent - first < n) begin
      if ($urandom_range(99) < 75) run_sequence();
      else send(rand_item());
    end
  endtask

  initial begin
    in_item_t it;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    send(mk_irq(5'h1F));
    send(mk_start(6'd17, RESP_136, 1'b1, 1'b1));
    send(mk_start(6'd17, RESP_136, 1'b1, 1'b0));
    send(mk_start(6'd18, RESP_48, 1'b0, 1'b0));
    send(mk_irq(5'd1 << IRQ_TC));
    send(mk_irq(5'd1 << IRQ_BRR));
    it = mk_irq(5'd1 << IRQ_CC);
    it.rsp_word0 = '1;
    it.rsp_word1 = '0;
    it.rsp_word2 = '1;
    it.rsp_word3 = 32'h12345678;
    send(it);
    send(mk_start(TUNING_RESET, RESP_48, 1'b1, 1'b0));
    send(mk_irq(5'd1 << IRQ_CC));
    send(mk_irq(5'd1 << IRQ_BWR));
    send(mk_irq(5'd1 << IRQ_BRR));
    send(mk_start(6'd0, RESP_NONE, 1'b0, 1'b0));
    send(mk_irq(5'd1 << IRQ_CC));
    send(mk_start(6'd63, RESP_48_BUSY, 1'b0, 1'b0));
    send(mk_irq((5'd1 << IRQ_BRR) | (5'd1 << IRQ_BWR)));
    send(mk_irq(5'd1 << IRQ_CC));
    send(mk_irq(5'd1 << IRQ_TC));
    send(mk_start(6'd5, RESP_48, 1'b1, 1'b0));
    send(mk_irq(5'h1F));
    send(mk_start(6'd6, RESP_136, 1'b1, 1'b0));
    send(mk_irq(5'd1 << IRQ_ERR));
    set_tuning(6'd6);
    send(mk_start(6'd6, RESP_48, 1'b1, 1'b0));
    send(mk_irq(5'd1 << IRQ_BRR));

    set_tuning(6'd0);
    tx_idle  = 0;
    rx_stall = 0;
    hold_req = 1'b1;
    run_random(400);

    set_tuning(6'd63);
    tx_idle  = 81;
    rx_stall = 0;
    run_random(400);

    set_tuning(IDX_W'($urandom));
    tx_idle  = 0;
    rx_stall = 81;
    run_random(400);

    set_tuning(TUNING_RESET);
    tx_idle  = 38;
    rx_stall = 38;
    run_random(400);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
